>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ppdt_pkg.sv
// ----------------------------------------------------------------------------
// ppdt_pkg
// Types, codes and sizes shared by the port pair demultiplex table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppdt_pkg;

  // Number of table slots.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Command codes.
  localparam logic [1:0] CMD_LOOKUP     = 2'd0;
  localparam logic [1:0] CMD_REGISTER   = 2'd1;
  localparam logic [1:0] CMD_UNREGISTER = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MATCH  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NO_HANDLE = 2'd3;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [15:0] handle;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;   // load the request and clear the scan results
    logic scan;    // step the table scan
    logic commit;  // update the table and load the result register
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> rtl/core/ppdt_req_if.sv
// ----------------------------------------------------------------------------
// ppdt_req_if
// Request channel: command, port pair and handle with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppdt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] local_port;
  logic [15:0] remote_port;
  logic [15:0] conn_handle;

  modport source (
    output valid, cmd, local_port, remote_port, conn_handle,
    input  ready
  );
  modport sink (
    input  valid, cmd, local_port, remote_port, conn_handle,
    output ready
  );
endinterface

>>> rtl/core/ppdt_rsp_if.sv
// ----------------------------------------------------------------------------
// ppdt_rsp_if
// Result channel: status and matched handle with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppdt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_handle;

  modport source (
    output valid, status, found_handle,
    input  ready
  );
  modport sink (
    input  valid, status, found_handle,
    output ready
  );
endinterface

>>> rtl/core/ppdt_ctrl.sv
// ----------------------------------------------------------------------------
// ppdt_ctrl
// Sequencer: accepts a request, runs the table scan, then commits the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppdt_ctrl import ppdt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready  = (state == S_IDLE);
  assign cmd.start  = req_valid && req_ready;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.commit = (state == S_FINISH) && sts.out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/ppdt_dp.sv
// ----------------------------------------------------------------------------
// ppdt_dp
// Datapath: entry memory, valid bits, scan evaluation and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppdt_dp import ppdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  output ctl_sts_t    sts,
  input  logic [1:0]  req_cmd_in,
  input  logic [15:0] req_local_port,
  input  logic [15:0] req_remote_port,
  input  logic [15:0] req_conn_handle,
  input  logic        rsp_ready,
  output logic        rsp_valid,
  output logic [1:0]  rsp_status,
  output logic [15:0] rsp_found_handle
);

  // Entry memory, one read port for the scan and one write port for commit.
  entry_t mem [TABLE_DEPTH];
  entry_t rd_entry;

  logic [TABLE_DEPTH-1:0] entry_valid;

  // Latched request.
  logic [1:0]  req_cmd;
  logic [15:0] req_lp;
  logic [15:0] req_rp;
  logic [15:0] req_h;

  // Scan position and the entry in evaluation, registered one step behind it.
  logic [CNT_W-1:0] cnt;
  logic             cnt_lt;
  logic             eval_v;
  logic [IDX_W-1:0] eval_idx;

  // Scan results.
  logic             exact_hit;
  logic [15:0]      exact_handle;
  logic             wild_hit;
  logic [15:0]      wild_handle;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;
  logic             hnd_hit;
  logic [IDX_W-1:0] hnd_idx;

  logic ev_valid;
  logic ev_lp_eq;
  logic ev_exact;
  logic ev_wild;
  logic ev_free;
  logic ev_hnd;

  logic [1:0]  res_status;
  logic [15:0] res_handle;

  assign cnt_lt   = (cnt != CNT_W'(TABLE_DEPTH));
  assign ev_valid = entry_valid[eval_idx];
  assign ev_lp_eq = (rd_entry.local_port == req_lp);
  assign ev_exact = eval_v && ev_valid && ev_lp_eq && (rd_entry.remote_port == req_rp);
  assign ev_wild  = eval_v && ev_valid && ev_lp_eq && (rd_entry.remote_port == 16'd0);
  assign ev_free  = eval_v && !ev_valid;
  assign ev_hnd   = eval_v && ev_valid && (rd_entry.handle == req_h);

  assign sts.scan_done = !cnt_lt && !eval_v;
  assign sts.out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    res_status = ST_OK;
    res_handle = 16'd0;
    case (req_cmd)
      CMD_LOOKUP: begin
        if (exact_hit) begin
          res_handle = exact_handle;
        end else if (wild_hit) begin
          res_handle = wild_handle;
        end else begin
          res_status = ST_NO_MATCH;
        end
      end
      CMD_REGISTER: begin
        if (!free_hit) res_status = ST_FULL;
      end
      CMD_UNREGISTER: begin
        if (!hnd_hit) res_status = ST_NO_HANDLE;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Memory port.
  always_ff @(posedge clk) begin
    if (cmd.commit && (req_cmd == CMD_REGISTER) && free_hit) begin
      mem[free_idx] <= '{local_port: req_lp, remote_port: req_rp, handle: req_h};
    end
    if (cmd.scan && cnt_lt) begin
      rd_entry <= mem[cnt[IDX_W-1:0]];
    end
  end

  // Request, scan results and result payload.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_cmd   <= req_cmd_in;
      req_lp    <= req_local_port;
      req_rp    <= req_remote_port;
      req_h     <= req_conn_handle;
      exact_hit <= 1'b0;
      wild_hit  <= 1'b0;
      free_hit  <= 1'b0;
      hnd_hit   <= 1'b0;
    end else begin
      if (ev_exact && !exact_hit) begin
        exact_hit    <= 1'b1;
        exact_handle <= rd_entry.handle;
      end
      // The last wildcard seen is the highest-indexed one.
      if (ev_wild) begin
        wild_hit    <= 1'b1;
        wild_handle <= rd_entry.handle;
      end
      if (ev_free && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= eval_idx;
      end
      if (ev_hnd && !hnd_hit) begin
        hnd_hit <= 1'b1;
        hnd_idx <= eval_idx;
      end
    end
    if (cmd.commit) begin
      rsp_status       <= res_status;
      rsp_found_handle <= res_handle;
    end
    if (cmd.scan && cnt_lt) begin
      eval_idx <= cnt[IDX_W-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      eval_v      <= 1'b0;
      entry_valid <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.start) begin
        cnt    <= '0;
        eval_v <= 1'b0;
      end else if (cmd.scan) begin
        eval_v <= cnt_lt;
        if (cnt_lt) cnt <= cnt + CNT_W'(1);
      end else begin
        eval_v <= 1'b0;
      end
      if (cmd.commit) begin
        if ((req_cmd == CMD_REGISTER) && free_hit) begin
          entry_valid[free_idx] <= 1'b1;
        end
        if ((req_cmd == CMD_UNREGISTER) && hnd_hit) begin
          entry_valid[hnd_idx] <= 1'b0;
        end
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/port_pair_demux_table.sv
// ----------------------------------------------------------------------------
// port_pair_demux_table
// Connection demultiplex table mapping a local/remote port pair to a handle.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one command per beat: lookup, register or
//   unregister, with the port pair and the connection handle. The rsp
//   channel returns exactly one beat per request, with a status code and,
//   for a successful lookup, the matched handle (zero otherwise).
//   Each request walks the whole table, one slot per cycle, through the
//   single read port of the entry memory; the walk sets the timing. The
//   result is loaded into the output register once the scan ends and the
//   register is free, and the next request is taken the cycle after the
//   result is loaded, so a new request waits for the previous scan to end.
//   Reset (rst, synchronous) clears every valid bit, so the table starts
//   empty, and drops any pending result; no clearing pass is needed.
//   The result sits in an output register. A new request is accepted while
//   it waits; if the receiver is still stalling when the next scan ends, the
//   block holds that scan's result and its table update until the register
//   frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module port_pair_demux_table import ppdt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ppdt_req_if.sink   req,
  ppdt_rsp_if.source rsp
);

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  // The sequencer owns the request handshake and paces the datapath.
  ppdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (ctl_sts),
    .cmd       (ctl_cmd)
  );

  // The datapath holds the table, evaluates one slot per cycle and drives
  // the result register directly onto the rsp channel.
  ppdt_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (ctl_cmd),
    .sts              (ctl_sts),
    .req_cmd_in       (req.cmd),
    .req_local_port   (req.local_port),
    .req_remote_port  (req.remote_port),
    .req_conn_handle  (req.conn_handle),
    .rsp_ready        (rsp.ready),
    .rsp_valid        (rsp.valid),
    .rsp_status       (rsp.status),
    .rsp_found_handle (rsp.found_handle)
  );

  // An accepted request must start a scan in the following cycle.
  `ASSERT_NEXT(a_accept_starts_scan, req.valid && req.ready, ctl_cmd.scan,
    "accepted request did not start a scan")

  // A result is only committed when the output register can take it.
  `ASSERT_IMPLIES(a_commit_when_free, ctl_cmd.commit, !rsp.valid || rsp.ready,
    "result committed over an untaken result")

  // A new result beat only appears after a commit.
  `ASSERT_IMPLIES(a_valid_from_commit, $rose(rsp.valid), $past(ctl_cmd.commit),
    "result beat without a commit")

  // A nonzero handle is only reported with an ok status.
  `ASSERT_IMPLIES(a_handle_means_ok, rsp.valid && (rsp.found_handle != 16'd0),
    rsp.status == ST_OK, "handle reported with a failure status")

endmodule
